### rtl/sfrp_pkg.sv
// Shared types, constants and register codes of the frequency register planner.
`timescale 1ns / 1ps

package sfrp_pkg;

    // Default depth of the queue between front and back
    localparam int unsigned QueueDepth = 2;

    localparam logic [31:0] LOW_FREQ_LIMIT  = 32'd500000;
    localparam logic [31:0] HIGH_FREQ_LIMIT = 32'd30000000;
    localparam logic [31:0] NUDGE_HZ        = 32'd5000;
    localparam logic [31:0] P1_OFFSET       = 32'd512;
    localparam logic [7:0]  CTRL_BASE       = 8'h6C;
    localparam logic [7:0]  PLL_RST_VALUE   = 8'hA0;
    localparam logic [7:0]  PLL_RST_ADDR    = 8'd177;
    localparam logic [7:0]  P3_HIGH_MASK    = 8'hF0;
    localparam logic [7:0]  PLL_BASE_ADDR   = 8'd34;
    localparam logic [7:0]  MS_BASE_ADDR    = 8'd42;
    localparam logic [7:0]  CTRL_BASE_ADDR  = 8'd16;
    localparam logic [2:0]  RDIV_LOW_BAND   = 3'd7;

    localparam logic [25:0] XTAL_RESET  = 26'd25000000;
    localparam logic [1:0]  DRIVE_RESET = 2'd0;
    localparam logic [19:0] DENOM_RESET = 20'd1048575;

    // Divider: wide dividend width, short dividend width
    localparam int unsigned DIV_W     = 56;
    localparam int unsigned DIV_SHORT = 32;

    typedef enum logic [1:0] {
        REG_XTAL  = 2'd0,
        REG_DRIVE = 2'd1,
        REG_DENOM = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [27:0] out_freq_hz;
        logic [2:0]  out_index;
    } req_t;

    typedef struct packed {
        logic [7:0] reg_address;
        logic [7:0] reg_value;
        logic       last_write;
    } wr_t;

    // Request after band classification
    typedef struct packed {
        logic [31:0] freq;
        logic        low_band;
        logic        high_band;
        logic [2:0]  out_index;
    } cls_t;

    typedef struct packed {
        logic [25:0] xtal_hz;
        logic [1:0]  drive_strength;
        logic [19:0] frac_denominator;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic             wide;
        logic [DIV_W-1:0] dividend;
        logic [31:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [31:0]      remainder;
    } div_rsp_t;

endpackage

### rtl/sfrp_front.sv
// Front end: takes requests and classifies the frequency band.
`timescale 1ns / 1ps

module sfrp_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  sfrp_pkg::req_t  req,
    output logic            push_valid,
    input  logic            push_ready,
    output sfrp_pkg::cls_t  push_data
);

    logic           valid_reg;
    logic           valid_next;
    sfrp_pkg::cls_t cls_reg;
    sfrp_pkg::cls_t cls_next;
    logic [31:0]    f_raw;
    logic [31:0]    f_scaled;
    logic           low;

    assign req_ready  = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_data  = cls_reg;

    always_comb
    begin
        f_raw    = {4'b0, req.out_freq_hz};
        low      = f_raw < sfrp_pkg::LOW_FREQ_LIMIT;
        // low band is scaled by 128
        f_scaled = low ? {f_raw[24:0], 7'b0} : f_raw;
        cls_next.freq      = f_scaled;
        cls_next.low_band  = low;
        cls_next.high_band = f_scaled > sfrp_pkg::HIGH_FREQ_LIMIT;
        cls_next.out_index = req.out_index;
    end

    always_comb
    begin
        if (req_valid && req_ready)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            cls_reg <= cls_next;
        end
    end

endmodule

### rtl/sfrp_queue.sv
// Short queue of classified requests between front and back.
`timescale 1ns / 1ps

module sfrp_queue
#(
    parameter int unsigned DEPTH = sfrp_pkg::QueueDepth
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  sfrp_pkg::cls_t  push_data,
    output logic            pop_valid,
    input  logic            pop,
    output sfrp_pkg::cls_t  pop_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    sfrp_pkg::cls_t mem [DEPTH];
    logic [PW-1:0]  wptr_reg;
    logic [PW-1:0]  wptr_next;
    logic [PW-1:0]  rptr_reg;
    logic [PW-1:0]  rptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wptr_reg] <= push_data;
        end
    end

endmodule

### rtl/sfrp_div.sv
// Bit-serial restoring divider shared by all divisions of the back end.
`timescale 1ns / 1ps

module sfrp_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  sfrp_pkg::div_req_t  req,
    output sfrp_pkg::div_rsp_t  rsp
);

    localparam int unsigned W  = sfrp_pkg::DIV_W;
    localparam int unsigned SW = sfrp_pkg::DIV_SHORT;
    localparam int unsigned CW = $clog2(W);

    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [31:0]   rem_reg;
    logic [31:0]   rem_next;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  quo_next;
    logic [31:0]   dsr_reg;
    logic [31:0]   dsr_next;
    logic [32:0]   shifted;
    logic [33:0]   diff;
    logic          fits;

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[W-1]};
        diff      = {1'b0, shifted} - {2'b0, dsr_reg};
        fits      = !diff[33];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            dsr_next = req.divisor;
            if (req.divisor == '0)
            begin
                // zero divisor: quotient 0, remainder is the low 32 bits of the dividend
                busy_next = 1'b0;
                done_next = 1'b1;
                quo_next  = '0;
                rem_next  = req.dividend[31:0];
            end
            else
            begin
                busy_next = 1'b1;
                rem_next  = '0;
                quo_next  = req.wide ? req.dividend
                                     : {req.dividend[SW-1:0], (W-SW)'(0)};
                cnt_next  = req.wide ? CW'(W - 1) : CW'(SW - 1);
            end
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[31:0] : shifted[31:0];
            quo_next = {quo_reg[W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

endmodule

### rtl/sfrp_back.sv
// Back end: divider sequence, PLL state and register write emission.
`timescale 1ns / 1ps

module sfrp_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  sfrp_pkg::cfg_t  cfg,
    input  logic            item_valid,
    output logic            item_pop,
    input  sfrp_pkg::cls_t  item,
    output logic            wr_valid,
    input  logic            wr_ready,
    output sfrp_pkg::wr_t   wr
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_DIV_D    = 9'b000000010,
        ST_DIV_LO   = 9'b000000100,
        ST_DIV_HI   = 9'b000001000,
        ST_VCO_MUL  = 9'b000010000,
        ST_DIV_VCO  = 9'b000100000,
        ST_DIV_FRAC = 9'b001000000,
        ST_DIV_P    = 9'b010000000,
        ST_EMIT     = 9'b100000000
    } state_t;

    localparam logic [4:0] EMIT_CTRL = 5'd16;
    localparam logic [4:0] EMIT_RST  = 5'd17;

    state_t               state_reg;
    state_t               state_next;
    logic [31:0]          f_reg;
    logic [31:0]          f_next;
    logic                 low_reg;
    logic                 low_next;
    logic [2:0]           idx_reg;
    logic [2:0]           idx_next;
    logic [15:0]          d_reg;
    logic [15:0]          d_next;
    logic [31:0]          qlo_reg;
    logic [31:0]          qlo_next;
    logic [7:0]           msa_reg;
    logic [7:0]           msa_next;
    logic [31:0]          p1_reg;
    logic [31:0]          p1_next;
    logic [23:0]          p2_reg;
    logic [23:0]          p2_next;
    logic                 rst_reg;
    logic                 rst_next;
    logic [4:0]           cnt_reg;
    logic [4:0]           cnt_next;
    logic [7:0]           last_msa_reg;
    logic [7:0]           last_msa_next;
    logic                 known_reg;
    logic                 known_next;
    logic                 wr_valid_reg;
    logic                 wr_valid_next;
    sfrp_pkg::wr_t        wr_reg;
    sfrp_pkg::wr_t        wr_next;

    sfrp_pkg::div_req_t   div_req;
    sfrp_pkg::div_rsp_t   div_rsp;

    logic [29:0]          xtal_x16;
    logic [31:0]          xtal_x34;
    logic [47:0]          lo_prod;
    logic [47:0]          hi_prod;
    logic [47:0]          vco_prod;
    logic [51:0]          frac_prod;
    logic [31:0]          m1;
    logic [7:0]           pll_byte [8];
    logic [7:0]           ms_byte [8];
    logic                 emit_go;
    logic                 emit_last;

    sfrp_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign wr_valid = wr_valid_reg;
    assign wr       = wr_reg;
    assign item_pop = (state_reg == ST_IDLE) && item_valid;

    // operand products feeding the divider input registers
    always_comb
    begin
        xtal_x16  = {cfg.xtal_hz, 4'b0};
        // 34 * xtal needs the full 32 bits at the top of the crystal range
        xtal_x34  = {1'b0, cfg.xtal_hz, 5'b0} + {5'b0, cfg.xtal_hz, 1'b0};
        lo_prod   = div_rsp.quotient[15:0] * (f_reg - sfrp_pkg::NUDGE_HZ);
        hi_prod   = d_reg * (f_reg + sfrp_pkg::NUDGE_HZ);
        vco_prod  = d_reg * f_reg;
        frac_prod = div_rsp.remainder * cfg.frac_denominator;
    end

    // output byte tables
    always_comb
    begin
        m1 = ({9'b0, d_reg, 7'b0} - sfrp_pkg::P1_OFFSET)
           | {9'b0, (low_reg ? sfrp_pkg::RDIV_LOW_BAND : 3'd0), 20'b0};
        pll_byte[0] = cfg.frac_denominator[15:8];
        pll_byte[1] = cfg.frac_denominator[7:0];
        pll_byte[2] = p1_reg[23:16];
        pll_byte[3] = p1_reg[15:8];
        pll_byte[4] = p1_reg[7:0];
        pll_byte[5] = ({cfg.frac_denominator[19:16], 4'b0} & sfrp_pkg::P3_HIGH_MASK)
                    | p2_reg[23:16];
        pll_byte[6] = p2_reg[15:8];
        pll_byte[7] = p2_reg[7:0];
        ms_byte[0]  = 8'd0;
        ms_byte[1]  = 8'd1;
        ms_byte[2]  = m1[23:16];
        ms_byte[3]  = m1[15:8];
        ms_byte[4]  = m1[7:0];
        ms_byte[5]  = 8'd0;
        ms_byte[6]  = 8'd0;
        ms_byte[7]  = 8'd0;
    end

    always_comb
    begin
        emit_go   = (state_reg == ST_EMIT) && (!wr_valid_reg || wr_ready);
        emit_last = (cnt_reg == EMIT_RST) || ((cnt_reg == EMIT_CTRL) && !rst_reg);
        wr_next   = wr_reg;
        case (cnt_reg[4:3])
            2'd0:
            begin
                wr_next.reg_address = sfrp_pkg::PLL_BASE_ADDR + {5'b0, cnt_reg[2:0]};
                wr_next.reg_value   = pll_byte[cnt_reg[2:0]];
            end
            2'd1:
            begin
                wr_next.reg_address = sfrp_pkg::MS_BASE_ADDR + {2'b0, idx_reg, 3'b0}
                                    + {5'b0, cnt_reg[2:0]};
                wr_next.reg_value   = ms_byte[cnt_reg[2:0]];
            end
            2'd2:
            begin
                if (cnt_reg == EMIT_CTRL)
                begin
                    wr_next.reg_address = sfrp_pkg::CTRL_BASE_ADDR + {5'b0, idx_reg};
                    wr_next.reg_value   = sfrp_pkg::CTRL_BASE | {6'b0, cfg.drive_strength};
                end
                else
                begin
                    wr_next.reg_address = sfrp_pkg::PLL_RST_ADDR;
                    wr_next.reg_value   = sfrp_pkg::PLL_RST_VALUE;
                end
            end
            default:
            begin
                wr_next.reg_address = 8'd0;
                wr_next.reg_value   = 8'd0;
            end
        endcase
        wr_next.last_write = emit_last;
        if (emit_go)
        begin
            wr_valid_next = 1'b1;
        end
        else if (wr_ready)
        begin
            wr_valid_next = 1'b0;
        end
        else
        begin
            wr_valid_next = wr_valid_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        f_next           = f_reg;
        low_next         = low_reg;
        idx_next         = idx_reg;
        d_next           = d_reg;
        qlo_next         = qlo_reg;
        msa_next         = msa_reg;
        p1_next          = p1_reg;
        p2_next          = p2_reg;
        rst_next         = rst_reg;
        cnt_next         = cnt_reg;
        last_msa_next    = last_msa_reg;
        known_next       = known_reg;
        div_req.start    = 1'b0;
        div_req.wide     = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = {6'b0, cfg.xtal_hz};
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    f_next           = item.freq;
                    low_next         = item.low_band;
                    idx_next         = item.out_index;
                    div_req.start    = 1'b1;
                    div_req.dividend = item.high_band ? {24'b0, xtal_x34}
                                                      : {26'b0, xtal_x16};
                    div_req.divisor  = item.freq;
                    state_next       = ST_DIV_D;
                end
            end
            ST_DIV_D:
            begin
                if (div_rsp.done)
                begin
                    d_next           = div_rsp.quotient[15:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = {24'b0, lo_prod[31:0]};
                    state_next       = ST_DIV_LO;
                end
            end
            ST_DIV_LO:
            begin
                if (div_rsp.done)
                begin
                    qlo_next         = div_rsp.quotient[31:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = {24'b0, hi_prod[31:0]};
                    state_next       = ST_DIV_HI;
                end
            end
            ST_DIV_HI:
            begin
                if (div_rsp.done)
                begin
                    // nudge down when the band edges straddle an integer
                    if (qlo_reg != div_rsp.quotient[31:0])
                    begin
                        d_next = d_reg - 1'b1;
                    end
                    state_next = ST_VCO_MUL;
                end
            end
            ST_VCO_MUL:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {24'b0, vco_prod[31:0]};
                state_next       = ST_DIV_VCO;
            end
            ST_DIV_VCO:
            begin
                if (div_rsp.done)
                begin
                    msa_next         = div_rsp.quotient[7:0];
                    div_req.start    = 1'b1;
                    div_req.wide     = 1'b1;
                    div_req.dividend = {frac_prod[48:0], 7'b0};
                    state_next       = ST_DIV_FRAC;
                end
            end
            ST_DIV_FRAC:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {24'b0, div_rsp.quotient[31:0]};
                    div_req.divisor  = {12'b0, cfg.frac_denominator};
                    state_next       = ST_DIV_P;
                end
            end
            ST_DIV_P:
            begin
                if (div_rsp.done)
                begin
                    p1_next = {17'b0, msa_reg, 7'b0} + div_rsp.quotient[31:0]
                            - sfrp_pkg::P1_OFFSET;
                    p2_next = div_rsp.remainder[23:0];
                    rst_next = !known_reg || (last_msa_reg != msa_reg);
                    last_msa_next = msa_reg;
                    known_next    = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            last_msa_reg <= '0;
            known_reg    <= 1'b0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            last_msa_reg <= last_msa_next;
            known_reg    <= known_next;
            wr_valid_reg <= wr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg   <= f_next;
        low_reg <= low_next;
        idx_reg <= idx_next;
        d_reg   <= d_next;
        qlo_reg <= qlo_next;
        msa_reg <= msa_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        rst_reg <= rst_next;
        if (emit_go)
        begin
            wr_reg <= wr_next;
        end
    end

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_known_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(known_reg))
        else $error("PLL integer record lost");

    a_emit_known: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> known_reg)
        else $error("emitting without a kept PLL integer");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV_D || state_reg == ST_DIV_LO
                          || state_reg == ST_DIV_HI || state_reg == ST_DIV_VCO
                          || state_reg == ST_DIV_FRAC || state_reg == ST_DIV_P))
        else $error("divider result with no division pending");
`endif

endmodule

### rtl/synth_frequency_register_planner.sv
// Top level of the frequency register planner: config registers and block wiring.
`timescale 1ns / 1ps

// Usage
//   req channel (req_valid/req_ready/req): one transfer per frequency request,
//   carrying out_freq_hz and out_index.
//   wr channel (wr_valid/wr_ready/wr): one transfer per device register write,
//   17 or 18 per request, in order; last_write marks the final one.
//   APB port: xtal_hz at 0x0, drive_strength at 0x4, frac_denominator at 0x8.
//   Write registers only while the block is idle.
// Sequence
//   A request runs six divisions on one bit-serial divider (five on 32-bit
//   dividends, one on a 56-bit), then emits its writes at one per cycle
//   with wr_ready held high; the divider sets most of the request time.
//   A zero crystal or denominator shortens it.
//   The front stage and queue take further requests while one is in work.
// Reset
//   rst_n clears the queue and sequencer, restores the register defaults and
//   forgets the kept PLL integer, so the first request always adds a PLL reset.
// Stalls
//   With wr_ready low the current write is held and the sequencer waits;
//   requests back up into the queue and then req_ready drops.

module synth_frequency_register_planner
#(
    parameter int unsigned QUEUE_DEPTH = sfrp_pkg::QueueDepth
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  sfrp_pkg::req_t  req,
    output logic            wr_valid,
    input  logic            wr_ready,
    output sfrp_pkg::wr_t   wr,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    sfrp_pkg::cfg_t     cfg_reg;
    sfrp_pkg::cfg_t     cfg_next;
    sfrp_pkg::reg_idx_t reg_idx;
    logic               cfg_wr;

    logic               push_valid;
    logic               push_ready;
    sfrp_pkg::cls_t     push_data;
    logic               pop_valid;
    logic               pop;
    sfrp_pkg::cls_t     pop_data;

    assign pready  = 1'b1;
    assign reg_idx = sfrp_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // register file; writes past the last register are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        case (reg_idx)
            sfrp_pkg::REG_XTAL:
            begin
                prdata = {6'b0, cfg_reg.xtal_hz};
                if (cfg_wr)
                begin
                    cfg_next.xtal_hz = pwdata[25:0];
                end
            end
            sfrp_pkg::REG_DRIVE:
            begin
                prdata = {30'b0, cfg_reg.drive_strength};
                if (cfg_wr)
                begin
                    cfg_next.drive_strength = pwdata[1:0];
                end
            end
            sfrp_pkg::REG_DENOM:
            begin
                prdata = {12'b0, cfg_reg.frac_denominator};
                if (cfg_wr)
                begin
                    cfg_next.frac_denominator = pwdata[19:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.xtal_hz          <= sfrp_pkg::XTAL_RESET;
            cfg_reg.drive_strength   <= sfrp_pkg::DRIVE_RESET;
            cfg_reg.frac_denominator <= sfrp_pkg::DENOM_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sfrp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    sfrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    sfrp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (pop_valid),
        .item_pop   (pop),
        .item       (pop_data),
        .wr_valid   (wr_valid),
        .wr_ready   (wr_ready),
        .wr         (wr)
    );

endmodule

### bench/tb_synth_frequency_register_planner.sv
// Self-checking testbench for the frequency register planner.
`timescale 1ns / 1ps

// Scoreboard: predicts the register writes each request causes and checks them in order.
class write_plan_scoreboard;
    logic [25:0]   xtal;
    logic [1:0]    drive;
    logic [19:0]   denom;
    logic [7:0]    kept_integer;
    bit            integer_known;
    sfrp_pkg::wr_t planned_writes[$];
    int            mismatches;

    function new();
        xtal          = sfrp_pkg::XTAL_RESET;
        drive         = sfrp_pkg::DRIVE_RESET;
        denom         = sfrp_pkg::DENOM_RESET;
        kept_integer  = '0;
        integer_known = 0;
        mismatches    = 0;
    endfunction

    function logic [31:0] quo(logic [31:0] a, logic [31:0] b);
        return (b == 0) ? 32'd0 : a / b;
    endfunction

    function void push_write(logic [31:0] addr, logic [31:0] val);
        sfrp_pkg::wr_t w;
        w.reg_address = addr[7:0];
        w.reg_value   = val[7:0];
        w.last_write  = 1'b0;
        planned_writes.push_back(w);
    endfunction

    // Note an accepted request and queue its writes
    function void note_request(sfrp_pkg::req_t rq);
        logic [31:0] f, r, c, rdiv, d, fvco, msa, b128, p1, p2, m1, idx, base;
        logic [63:0] wide;
        sfrp_pkg::wr_t w;
        f    = {4'd0, rq.out_freq_hz};
        idx  = {29'd0, rq.out_index};
        r    = {6'd0, xtal};
        c    = {12'd0, denom};
        rdiv = 0;
        if (f < sfrp_pkg::LOW_FREQ_LIMIT)
        begin
            rdiv = 7;
            f    = f * 128;
        end
        d = quo(16 * r, f) & 32'hFFFF;
        if (f > sfrp_pkg::HIGH_FREQ_LIMIT)
            d = quo(34 * r, f) & 32'hFFFF;
        if (quo(d * (f - sfrp_pkg::NUDGE_HZ), r) != quo(d * (f + sfrp_pkg::NUDGE_HZ), r))
            d = (d - 1) & 32'hFFFF;
        fvco = d * f;
        msa  = quo(fvco, r) & 32'hFF;
        if (r == 0)
            b128 = 0;
        else
        begin
            wide = {32'd0, fvco % r} * {32'd0, c} * 64'd128;
            wide = wide / {32'd0, r};
            b128 = wide[31:0];
        end
        p1 = 128 * msa + quo(b128, c) - sfrp_pkg::P1_OFFSET;
        p2 = b128 - quo(b128, c) * c;
        push_write(34, c >> 8);
        push_write(35, c);
        push_write(36, p1 >> 16);
        push_write(37, p1 >> 8);
        push_write(38, p1);
        push_write(39, ((c >> 12) & 32'hF0) | (p2 >> 16));
        push_write(40, p2 >> 8);
        push_write(41, p2);
        m1   = (128 * d - sfrp_pkg::P1_OFFSET) | (rdiv << 20);
        base = 42 + idx * 8;
        push_write(base + 0, 0);
        push_write(base + 1, 1);
        push_write(base + 2, m1 >> 16);
        push_write(base + 3, m1 >> 8);
        push_write(base + 4, m1);
        push_write(base + 5, 0);
        push_write(base + 6, 0);
        push_write(base + 7, 0);
        push_write(16 + idx, {24'd0, sfrp_pkg::CTRL_BASE | {6'd0, drive}});
        if (!integer_known || kept_integer != msa[7:0])
        begin
            kept_integer  = msa[7:0];
            integer_known = 1;
            push_write(sfrp_pkg::PLL_RST_ADDR, sfrp_pkg::PLL_RST_VALUE);
        end
        w = planned_writes.pop_back();
        w.last_write = 1'b1;
        planned_writes.push_back(w);
    endfunction

    function void report(string what, sfrp_pkg::wr_t exp_w, sfrp_pkg::wr_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0s: expected addr=%0d val=%02h last=%0b, %0s",
                what, exp_w.reg_address, exp_w.reg_value, exp_w.last_write,
                $sformatf("got addr=%0d val=%02h last=%0b",
                    got.reg_address, got.reg_value, got.last_write));
    endfunction

    // Check one accepted write against the oldest planned one
    function void check_write(sfrp_pkg::wr_t got);
        sfrp_pkg::wr_t exp_w;
        if (planned_writes.size() == 0)
        begin
            report("unexpected write", '0, got);
            return;
        end
        exp_w = planned_writes.pop_front();
        if (got.reg_address !== exp_w.reg_address)
            report("reg_address", exp_w, got);
        else if (got.reg_value !== exp_w.reg_value)
            report("reg_value", exp_w, got);
        else if (got.last_write !== exp_w.last_write)
            report("last_write", exp_w, got);
    endfunction
endclass

module tb_synth_frequency_register_planner;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    sfrp_pkg::req_t req;
    logic           wr_valid;
    logic           wr_ready;
    sfrp_pkg::wr_t  wr;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [3:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    write_plan_scoreboard plan;
    longint unsigned      cycle_count;
    // receiver hold-off request, in cycles; served by the sink process
    int                   sink_hold;

    synth_frequency_register_planner u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .wr_valid  (wr_valid),
        .wr_ready  (wr_ready),
        .wr        (wr),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle limit: the processing of every request plus the random stalls on each
    // of its up to 18 writes and on the request, plus the long hold-offs; taken well over.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Write sink: random stalls, with long hold-offs on demand
    initial
    begin
        int gap;
        wr_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (sink_hold > 0)
            begin
                wr_ready <= 1'b0;
                repeat (sink_hold) @(posedge clk);
                sink_hold = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                wr_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            wr_ready <= 1'b1;
            @(posedge clk);
            while (!wr_valid) @(posedge clk);
            plan.check_write(wr);
        end
    end

    // APB write: setup then access
    task automatic apb_write(sfrp_pkg::reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            sfrp_pkg::REG_XTAL:  plan.xtal  = value[25:0];
            sfrp_pkg::REG_DRIVE: plan.drive = value[1:0];
            default:             plan.denom = value[19:0];
        endcase
    endtask

    // Offer one request after a random gap, hold it until taken
    task automatic send_request(logic [27:0] freq, logic [2:0] idx, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid         <= 1'b1;
        req.out_freq_hz   <= freq;
        req.out_index     <= idx;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        plan.note_request(req);
    endtask

    task automatic finish_request_stream();
        req_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Let every planned write arrive, then allow the block to settle
    task automatic drain();
        finish_request_stream();
        while (plan.planned_writes.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    function automatic logic [27:0] random_freq();
        case ($urandom_range(0, 5))
            0:       return 28'($urandom_range(8000, 499999));
            1:       return 28'($urandom_range(500000, 30000000));
            2:       return 28'($urandom_range(30000001, 160000000));
            3:       return 28'($urandom_range(3000000, 15000000));
            4:       return 28'($urandom);
            default: return 28'($urandom_range(1000000, 8000000));
        endcase
    endfunction

    // Random requests; near repeats of the last frequency exercise the kept integer
    task automatic random_burst(int count);
        logic [27:0] f;
        f = random_freq();
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) != 0)
                f = random_freq();
            else
                f = f + 28'($urandom_range(0, 200));
            send_request(f, 3'($urandom_range(0, 7)), $urandom_range(0, 4) == 0);
        end
    endtask

    initial
    begin
        plan          = new();
        sink_hold     = 0;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, bands, every index, special cases
        send_request(28'd8000, 3'd0, 0);
        send_request(28'd8000, 3'd1, 0);          // same integer: no PLL reset
        send_request(28'd499999, 3'd2, 0);
        send_request(28'd500000, 3'd3, 0);
        send_request(28'd30000000, 3'd4, 0);
        send_request(28'd30000001, 3'd5, 0);
        send_request(28'd160000000, 3'd6, 0);
        send_request(28'hFFFFFFF, 3'd7, 0);       // all ones
        send_request(28'd0, 3'd0, 0);             // zero frequency
        send_request(28'd1, 3'd1, 0);
        send_request(28'd7050000, 3'd2, 0);
        send_request(28'd10140200, 3'd3, 0);
        drain();

        // Zero crystal and zero denominator: divisions by zero
        apb_write(sfrp_pkg::REG_XTAL, 32'd0);
        apb_write(sfrp_pkg::REG_DENOM, 32'd0);
        apb_write(sfrp_pkg::REG_DRIVE, 32'd3);
        send_request(28'd7000000, 3'd0, 0);
        send_request(28'd100000, 3'd5, 0);
        drain();
        apb_write(sfrp_pkg::REG_XTAL, 32'd25000000);
        send_request(28'd14000000, 3'd1, 0);      // zero denominator only
        drain();
        apb_write(sfrp_pkg::REG_XTAL, 32'h3FFFFFF);
        apb_write(sfrp_pkg::REG_DENOM, 32'hFFFFF);
        apb_write(sfrp_pkg::REG_DRIVE, 32'd1);
        send_request(28'd8000, 3'd4, 0);
        send_request(28'hFFFFFFF, 3'd5, 0);
        send_request(28'd30000001, 3'd0, 0);     // top crystal, high band
        drain();

        // Extremes of the rated ranges
        apb_write(sfrp_pkg::REG_XTAL, 32'd10000000);
        apb_write(sfrp_pkg::REG_DENOM, 32'd1);
        apb_write(sfrp_pkg::REG_DRIVE, 32'd2);
        random_burst(30);
        // long receiver hold-off so the queue fills and the input stalls
        sink_hold = 600;
        random_burst(8);
        drain();

        apb_write(sfrp_pkg::REG_XTAL, 32'd40000000);
        apb_write(sfrp_pkg::REG_DENOM, 32'd1048575);
        apb_write(sfrp_pkg::REG_DRIVE, 32'd3);
        random_burst(40);
        drain();

        apb_write(sfrp_pkg::REG_XTAL, 32'($urandom_range(10000000, 40000000)));
        apb_write(sfrp_pkg::REG_DENOM, 32'($urandom_range(1, 1048575)));
        apb_write(sfrp_pkg::REG_DRIVE, 32'($urandom_range(0, 3)));
        random_burst(35);
        drain();

        apb_write(sfrp_pkg::REG_XTAL, 32'd25000000);
        apb_write(sfrp_pkg::REG_DENOM, 32'($urandom_range(1, 1000)));
        apb_write(sfrp_pkg::REG_DRIVE, 32'd0);
        random_burst(35);
        drain();

        if (plan.mismatches == 0 && plan.planned_writes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### synth_frequency_register_planner.f
rtl/sfrp_pkg.sv
rtl/sfrp_front.sv
rtl/sfrp_queue.sv
rtl/sfrp_div.sv
rtl/sfrp_back.sv
rtl/synth_frequency_register_planner.sv
bench/tb_synth_frequency_register_planner.sv
